// File: hw/rtl/sliding_window_maximum_macros.svh
// Assertion macros used by the sliding window maximum checker.
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

// Next-cycle implication, disabled while reset is held.
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define SWM_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

// Same-cycle implication, disabled while reset is held.
`define SWM_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/swm_pkg.sv
// Package with constants and types of the sliding window maximum block.
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int WIN_W      = 7;
    localparam int STAMP_W    = $clog2(2 * MAX_WINDOW);
    localparam int SEEN_W     = $clog2(MAX_WINDOW + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [STAMP_W-1:0]         stamp;
        logic                       valid;
        logic                       expired;
        logic                       keep;
        logic                       kept;
    } t_link;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] key;
        logic [STAMP_W-1:0]         pos;
        logic [STAMP_W-1:0]         stamp_new;
        logic [STAMP_W-1:0]         win;
        logic                       sos;
        logic                       step;
        logic                       purge;
        logic                       shift;
    } t_ctrl;

endpackage

// File: hw/rtl/swm_cell.sv
// One candidate cell of the sorted candidate chain.
module swm_cell
    import swm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_link i_right,
    input  logic  i_left_kept,
    output t_link o_link
);

    logic signed [SAMPLE_W-1:0] r_value, n_value;
    logic [STAMP_W-1:0]         r_stamp, n_stamp;
    logic                       r_valid, n_valid;
    logic [STAMP_W-1:0]         age;
    logic                       expired;
    logic                       keep;
    logic                       kept;
    logic                       insert;

    always_comb begin
        age     = i_ctrl.pos - r_stamp;
        expired = r_valid && (age >= i_ctrl.win);
        keep    = r_valid && !i_ctrl.sos && !expired && (r_value > i_ctrl.key);
        kept    = i_ctrl.shift ? i_right.keep : keep;
        insert  = !kept && i_left_kept;
    end

    always_comb begin
        n_value = r_value;
        n_stamp = r_stamp;
        n_valid = r_valid;
        if (i_ctrl.purge) begin
            n_value = i_right.value;
            n_stamp = i_right.stamp;
            n_valid = i_right.valid;
        end else if (i_ctrl.step) begin
            n_valid = kept || insert;
            if (insert) begin
                n_value = i_ctrl.key;
                n_stamp = i_ctrl.stamp_new;
            end else if (i_ctrl.shift) begin
                n_value = i_right.value;
                n_stamp = i_right.stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_stamp <= n_stamp;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_link = '{value:   r_value,
                      stamp:   r_stamp,
                      valid:   r_valid,
                      expired: expired,
                      keep:    keep,
                      kept:    kept};

endmodule

// File: hw/rtl/sliding_window_maximum.sv
// Each accepted sample's result is captured in a registered output stage.
// Throughput: one sample per cycle while the output is not stalled; after window_size
// shrinks, input is held off until candidates beyond the first that aged out of the new window are purged.
// Reset (i_rst_n low, synchronous) clears all candidates, counters and the output valid
// flag and sets window_size to 1.
module sliding_window_maximum
    import swm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [WIN_W-1:0]    i_cfg_wr_data,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [SAMPLE_W-1:0] i_s_axis_tdata,  // [31:0] sample
    input  logic                i_s_axis_tuser,  // [0] start_of_sequence
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [SAMPLE_W-1:0] o_m_axis_tdata   // [31:0] window_max
);

    logic [WIN_W-1:0]           r_win;
    logic [STAMP_W-1:0]         r_pos, n_pos;
    logic [SEEN_W-1:0]          r_seen, n_seen;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic [STAMP_W-1:0]         eff_win;
    logic                       step;
    logic                       purge;
    logic                       emit;
    logic signed [SAMPLE_W-1:0] result;
    t_ctrl                      ctrl;
    t_link                      links [MAX_WINDOW+1];
    logic                       kept_chain [MAX_WINDOW+1];

    always_comb begin
        if (r_win == '0) begin
            eff_win = STAMP_W'(1);
        end else if (r_win > WIN_W'(MAX_WINDOW)) begin
            eff_win = STAMP_W'(MAX_WINDOW);
        end else begin
            eff_win = STAMP_W'(r_win);
        end
    end

    assign purge           = links[1].expired;
    assign o_s_axis_tready = !purge && (!r_out_valid || i_m_axis_tready);
    assign step            = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        ctrl.key       = $signed(i_s_axis_tdata);
        ctrl.pos       = r_pos;
        ctrl.stamp_new = i_s_axis_tuser ? '0 : r_pos;
        ctrl.win       = eff_win;
        ctrl.sos       = i_s_axis_tuser;
        ctrl.step      = step;
        ctrl.purge     = purge;
        ctrl.shift     = links[0].expired && !i_s_axis_tuser;
    end

    assign links[MAX_WINDOW] = '0;
    assign kept_chain[0]     = 1'b1;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_right     (links[g+1]),
            .i_left_kept (kept_chain[g]),
            .o_link      (links[g])
        );
        assign kept_chain[g+1] = links[g].kept;
    end

    always_comb begin
        if (links[0].kept) begin
            result = ctrl.shift ? links[1].value : links[0].value;
        end else begin
            result = ctrl.key;
        end
    end

    always_comb begin
        n_pos = ctrl.stamp_new + STAMP_W'(1);
        if (i_s_axis_tuser) begin
            n_seen = SEEN_W'(1);
        end else if (r_seen == SEEN_W'(MAX_WINDOW)) begin
            n_seen = r_seen;
        end else begin
            n_seen = r_seen + SEEN_W'(1);
        end
        emit = STAMP_W'(n_seen) >= eff_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_W'(1);
            r_pos       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win <= i_cfg_wr_data;
            end
            if (step) begin
                r_pos       <= n_pos;
                r_seen      <= n_seen;
                r_out_valid <= emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: hw/rtl/swm_checker.sv
// Port-level checker for the sliding window maximum block, with its bind.
`include "sliding_window_maximum_macros.svh"

module swm_checker
    import swm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_wr_en,
    input logic [WIN_W-1:0]    i_cfg_wr_data,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [SAMPLE_W-1:0] i_s_axis_tdata,
    input logic                i_s_axis_tuser,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [SAMPLE_W-1:0] o_m_axis_tdata
);

    logic [WIN_W-1:0] r_win;
    logic             in_xfer;
    logic             unit_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(1);
        end else if (i_cfg_wr_en) begin
            r_win <= i_cfg_wr_data;
        end
    end

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign unit_win = (r_win <= WIN_W'(1));

    `SWM_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")
    `SWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output transaction dropped or changed while stalled")
    `SWM_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(in_xfer), "output transaction without accepted input")
    `SWM_ASSERT_NEXT(a_unit_window, i_clk, i_rst_n, in_xfer && unit_win, o_m_axis_tvalid && (o_m_axis_tdata == $past(i_s_axis_tdata)), "window of one must echo the sample")

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr_en     (i_cfg_wr_en),
    .i_cfg_wr_data   (i_cfg_wr_data),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: test/sliding_window_maximum_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_maximum: directed rows, then random items.
module sliding_window_maximum_tb;
    import swm_pkg::*;

    localparam int N_ROWS       = 24;
    localparam int RANDOM_ITEMS = 676;
    localparam int MAX_GAP      = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = N_ROWS + 100;
    localparam int MAX_REPORTS  = 10;
    localparam int LIMIT_NS     = 400000;

    typedef struct packed {
        logic                wr_cfg;
        logic [WIN_W-1:0]    win;
        logic [SAMPLE_W-1:0] sample;
        logic                sos;
        logic                fixed;
        logic [SAMPLE_W-1:0] expected;
    } t_row;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wr_en     = 1'b0;
    logic [WIN_W-1:0]    i_cfg_wr_data   = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [SAMPLE_W-1:0] i_s_axis_tdata  = '0;
    logic                i_s_axis_tuser  = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [SAMPLE_W-1:0] o_m_axis_tdata;
    logic                r_m_ready       = 1'b0;
    logic                r_hold          = 1'b0;

    logic [SAMPLE_W-1:0] exp_q [$];
    int                  n_sent     = 0;
    int                  n_mismatch = 0;

    logic signed [SAMPLE_W-1:0] m_value [MAX_WINDOW];
    logic [STAMP_W-1:0]         m_stamp [MAX_WINDOW];
    logic                       m_valid [MAX_WINDOW];
    int                         m_seen;
    logic [STAMP_W-1:0]         m_pos;
    logic [WIN_W-1:0]           m_win;

    t_row rows [N_ROWS] = '{
        '{1'b0, 7'd0,   32'd5,          1'b1, 1'b1, 32'd5},
        '{1'b0, 7'd0,   32'h8000_0000,  1'b0, 1'b1, 32'h8000_0000},
        '{1'b0, 7'd0,   32'h7FFF_FFFF,  1'b0, 1'b1, 32'h7FFF_FFFF},
        '{1'b1, 7'd3,   32'd1,          1'b1, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd2,          1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd2,          1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd0,          1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'hFFFF_FFFB,  1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'hFFFF_FFFA,  1'b0, 1'b0, 32'd0},
        '{1'b1, 7'd0,   32'd9,          1'b0, 1'b1, 32'd9},
        '{1'b1, 7'd8,   32'd100,        1'b1, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd90,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd80,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd70,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd60,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd50,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd40,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd30,         1'b0, 1'b0, 32'd0},
        '{1'b1, 7'd2,   32'd20,         1'b0, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'd25,         1'b0, 1'b0, 32'd0},
        '{1'b1, 7'd127, 32'd7,          1'b1, 1'b0, 32'd0},
        '{1'b0, 7'd0,   32'h8000_0000,  1'b0, 1'b0, 32'd0},
        '{1'b1, 7'd64,  32'h7FFF_FFFF,  1'b0, 1'b0, 32'd0}
    };

    assign i_m_axis_tready = r_m_ready && !r_hold;

    sliding_window_maximum i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic void model_reset();
        for (int i = 0; i < MAX_WINDOW; i++) begin
            m_value[i] = '0;
            m_stamp[i] = '0;
            m_valid[i] = 1'b0;
        end
        m_seen = 0;
        m_pos  = '0;
        m_win  = WIN_W'(1);
    endfunction

    function automatic void model_config(input logic [WIN_W-1:0] win);
        m_win = win;
    endfunction

    function automatic bit model_step(input logic signed [SAMPLE_W-1:0] sample,
                                      input logic sos,
                                      output logic signed [SAMPLE_W-1:0] res);
        int                         w;
        int                         free_cell;
        logic [STAMP_W-1:0]         age;
        bit                         have;
        logic signed [SAMPLE_W-1:0] best;
        if (m_win == '0) begin
            w = 1;
        end else if (int'(m_win) > MAX_WINDOW) begin
            w = MAX_WINDOW;
        end else begin
            w = int'(m_win);
        end
        free_cell = -1;
        have      = 1'b0;
        best      = '0;
        res       = '0;
        if (sos) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                m_valid[i] = 1'b0;
            end
            m_seen = 0;
            m_pos  = '0;
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (m_valid[i]) begin
                age = m_pos - m_stamp[i];
                if (int'(age) >= w || m_value[i] <= sample) begin
                    m_valid[i] = 1'b0;
                end
            end
            if (!m_valid[i] && free_cell < 0) begin
                free_cell = i;
            end
        end
        if (free_cell < 0) begin
            free_cell = 0;
        end
        m_value[free_cell] = sample;
        m_stamp[free_cell] = m_pos;
        m_valid[free_cell] = 1'b1;
        m_pos = m_pos + STAMP_W'(1);
        if (m_seen < MAX_WINDOW) begin
            m_seen++;
        end
        if (m_seen < w) begin
            return 1'b0;
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (m_valid[i] && (!have || m_value[i] > best)) begin
                best = m_value[i];
                have = 1'b1;
            end
        end
        res = best;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            return SAMPLE_W'($urandom);
        end else if (kind < 8) begin
            return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
        end else if (kind == 8) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic [SAMPLE_W-1:0] exp_v,
                                          input logic [SAMPLE_W-1:0] act_v);
        if (n_mismatch < MAX_REPORTS) begin
            $display("mismatch (%s): expected %0d, actual %0d",
                     what, $signed(exp_v), $signed(act_v));
        end
        n_mismatch++;
    endfunction

    task automatic write_cfg(input logic [WIN_W-1:0] win);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_q.size() != 0 || o_m_axis_tvalid) begin
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= win;
        model_config(win);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic sos,
                             input logic fixed, input logic [SAMPLE_W-1:0] expected);
        logic signed [SAMPLE_W-1:0] res;
        bit                         produced;
        int                         gap;
        produced = model_step($signed(sample), sos, res);
        if (fixed) begin
            exp_q.push_back(expected);
        end else if (produced) begin
            exp_q.push_back(res);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sample;
        i_s_axis_tuser  <= sos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : p_clock
        forever #1 i_clk = ~i_clk;
    end

    initial begin : p_reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : p_limit
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : p_pressure
        wait (n_sent >= HOLD_AFTER);
        @(posedge i_clk);
        r_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        r_hold <= 1'b0;
    end

    initial begin : p_receive
        int                  gap;
        logic [SAMPLE_W-1:0] exp_v;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            r_m_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            if (exp_q.size() == 0) begin
                note_mismatch("unexpected transaction", '0, o_m_axis_tdata);
            end else begin
                exp_v = exp_q.pop_front();
                if (o_m_axis_tdata !== exp_v) begin
                    note_mismatch("window_max", exp_v, o_m_axis_tdata);
                end
            end
            gap = $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                r_m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : p_send
        logic [WIN_W-1:0] win;
        logic             sos;
        model_reset();
        wait (i_rst_n);
        @(posedge i_clk);
        for (int r = 0; r < N_ROWS; r++) begin
            if (rows[r].wr_cfg) begin
                write_cfg(rows[r].win);
            end
            send_item(rows[r].sample, rows[r].sos, rows[r].fixed, rows[r].expected);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 39) == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    win = WIN_W'($urandom_range(0, 127));
                end else begin
                    win = WIN_W'($urandom_range(1, 12));
                end
                write_cfg(win);
            end
            sos = ($urandom_range(0, 24) == 0);
            send_item(pick_sample(), sos, 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;
        while (exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (n_mismatch == 0 && exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
